// ===== hdl/hbcc_pkg.sv =====
// Package with types, codes and commutation tables shared by the Hall commutation controller.
package hbcc_pkg;

   localparam int DutyWidth  = 8;
   localparam int CfgWidth   = 8;
   localparam int CsrAddrWidth = 8;
   localparam int PhaseWidth = 16;
   localparam int DivBits    = 20;
   localparam int DivCntWidth = $clog2(DivBits);

   localparam logic [1:0] KIND_CTRL  = 2'd0;
   localparam logic [1:0] KIND_STALL = 2'd1;
   localparam logic [1:0] KIND_RPM   = 2'd2;

   localparam logic [CsrAddrWidth-1:0] REG_STALL_WINDOW  = 8'd0;
   localparam logic [CsrAddrWidth-1:0] REG_CHARGE_ROUNDS = 8'd1;
   localparam logic [CsrAddrWidth-1:0] REG_RPM_WINDOW    = 8'd2;
   localparam logic [CsrAddrWidth-1:0] REG_RPM_DIVISOR   = 8'd3;

   localparam logic [3:0] HALL_EMPTY = 4'd8;

   typedef enum logic [2:0] {
      MODE_STOP   = 3'd0,
      MODE_CHARGE = 3'd1,
      MODE_CHECK  = 3'd2,
      MODE_RUN    = 3'd3,
      MODE_ERROR  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic apply;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } sts_type;

   // Hall code seen at each commutation step.
   function automatic logic [2:0] step_hall(input logic [2:0] idx);
      logic [2:0] r;
      unique case (idx)
         3'd0: r = 3'd2;
         3'd1: r = 3'd3;
         3'd2: r = 3'd1;
         3'd3: r = 3'd5;
         3'd4: r = 3'd4;
         3'd5: r = 3'd6;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Hall code that announces the following step.
   function automatic logic [2:0] step_next(input logic [2:0] idx);
      logic [2:0] r;
      unique case (idx)
         3'd0: r = 3'd3;
         3'd1: r = 3'd1;
         3'd2: r = 3'd5;
         3'd3: r = 3'd4;
         3'd4: r = 3'd6;
         3'd5: r = 3'd2;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] step_high(input logic [2:0] idx);
      logic [1:0] r;
      unique case (idx)
         3'd0, 3'd1: r = 2'd0;
         3'd2, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] step_low(input logic [2:0] idx);
      logic [1:0] r;
      unique case (idx)
         3'd0:       r = 2'd1;
         3'd1, 3'd2: r = 2'd2;
         3'd3, 3'd4: r = 2'd0;
         default:    r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/hbcc_ctrl.sv =====
// Sequencer that steps one transaction through execute, divide and result hand-off.
module hbcc_ctrl import hbcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: state_in = sts.need_div ? ST_DIV : ST_DONE;
         ST_DIV:  if (sts.div_last) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cmd.load     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.apply    = (state_ff == ST_EXEC);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.out_load = (state_ff == ST_DONE) && out_free;
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/hbcc_dp.sv =====
// Datapath: motor state, commutation logic, speed divider, settings and result register.
module hbcc_dp import hbcc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CfgWidth-1:0]     csr_data,
   input  logic [15:0]             req_tdata,
   input  logic [1:0]              req_tuser,
   output logic [39:0]             rsp_tdata,
   output logic [0:0]              rsp_tuser,
   input  cmd_type                 cmd,
   output sts_type                 sts
);

   logic [CfgWidth-1:0] stall_window_ff, charge_rounds_ff, rpm_window_ff, rpm_divisor_ff;

   logic [1:0]           kind_ff;
   logic [DutyWidth-1:0] duty_ff;
   logic [2:0]           hall_ff;

   mode_type             mode_ff, mode_in;
   logic [1:0]           chg_phase_ff, chg_phase_in;
   logic [7:0]           chg_count_ff, chg_count_in;
   logic [7:0]           stall_ff, stall_in;
   logic [3:0]           hist_ff [3];
   logic [3:0]           hist_in [3];
   logic [2:0]           step_ff, step_in;
   logic [2:0]           expected_ff, expected_in;
   logic                 pending_ff, pending_in;
   logic [DutyWidth-1:0] prev_duty_ff, prev_duty_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [7:0]           timer_ff, timer_in;
   logic [DutyWidth-1:0] high_ff [3];
   logic [DutyWidth-1:0] high_in [3];
   logic [2:0]           low_ff, low_in;
   logic [7:0]           speed_ff, speed_in;
   logic                 upd_ff, upd_in;

   logic [8:0]             rem_ff, rem_in;
   logic [DivBits-1:0]     quo_ff, quo_in;
   logic [DivCntWidth-1:0] cnt_ff, cnt_in;

   logic [DutyWidth-1:0] out_high_a_ff, out_high_b_ff, out_high_c_ff;
   logic [2:0]           out_low_ff;
   mode_type             out_mode_ff;
   logic [7:0]           out_speed_ff;
   logic                 out_upd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_window_ff  <= 8'd50;
         charge_rounds_ff <= 8'd10;
         rpm_window_ff    <= 8'd100;
         rpm_divisor_ff   <= 8'd10;
      end else if (csr_valid) begin
         unique case (csr_addr)
            REG_STALL_WINDOW:  stall_window_ff  <= csr_data;
            REG_CHARGE_ROUNDS: charge_rounds_ff <= csr_data;
            REG_RPM_WINDOW:    rpm_window_ff    <= csr_data;
            REG_RPM_DIVISOR:   rpm_divisor_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // The Hall inputs are active low; the code is their complement.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_tuser;
         duty_ff <= req_tdata[7:0];
         hall_ff <= ~req_tdata[10:8];
      end
   end

   always_comb begin
      logic [2:0]    stp;
      logic          pend;
      logic [7:0]    stl;
      logic          found;
      logic [2:0]    fidx;
      logic [8:0]    rem_sh;
      logic [DivBits-1:0] qn;

      mode_in      = mode_ff;
      chg_phase_in = chg_phase_ff;
      chg_count_in = chg_count_ff;
      stall_in     = stall_ff;
      hist_in      = hist_ff;
      step_in      = step_ff;
      expected_in  = expected_ff;
      pending_in   = pending_ff;
      prev_duty_in = prev_duty_ff;
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      speed_in     = speed_ff;
      upd_in       = upd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      sts.need_div = 1'b0;
      sts.div_last = (cnt_ff == '0);
      stp          = step_ff;
      pend         = pending_ff;
      stl          = stall_ff;
      found        = 1'b0;
      fidx         = 3'd0;
      rem_sh       = '0;
      qn           = '0;

      if (cmd.apply) begin
         upd_in = 1'b0;
         unique case (kind_ff)
            KIND_CTRL: begin
               prev_duty_in = duty_ff;
               unique case (mode_ff)
                  MODE_RUN: begin
                     if (duty_ff == '0) begin
                        mode_in = MODE_STOP;
                     end else begin
                        if (hall_ff == expected_ff) begin
                           stp         = (step_ff >= 3'd5) ? 3'd0 : step_ff + 3'd1;
                           pend        = 1'b1;
                           expected_in = step_next(stp);
                           stl         = '0;
                           if (phase_ff != '1) phase_in = phase_ff + 1'b1;
                        end
                        if (pend) begin
                           pend = 1'b0;
                           high_in = '{default: '0};
                           low_in  = '0;
                           high_in[step_high(stp)] = duty_ff;
                           low_in[step_low(stp)]   = 1'b1;
                        end
                        step_in    = stp;
                        pending_in = pend;
                        stall_in   = stl;
                        if (stl >= stall_window_ff) mode_in = MODE_ERROR;
                     end
                  end
                  MODE_CHARGE: begin
                     high_in = '{default: '0};
                     low_in  = '0;
                     if (chg_phase_ff != 2'd3) begin
                        low_in[chg_phase_ff] = 1'b1;
                        chg_phase_in = chg_phase_ff + 2'd1;
                     end else begin
                        chg_phase_in = '0;
                        chg_count_in = chg_count_ff + 8'd1;
                        if (chg_count_in >= charge_rounds_ff) begin
                           mode_in      = MODE_CHECK;
                           chg_count_in = '0;
                           stall_in     = '0;
                           hist_in      = '{default: HALL_EMPTY};
                        end
                     end
                  end
                  MODE_CHECK: begin
                     hist_in[2] = hist_ff[1];
                     hist_in[1] = hist_ff[0];
                     hist_in[0] = {1'b0, hall_ff};
                     for (int i = 0; i < 6; i++) begin
                        if (!found && step_hall(3'(i)) == hall_ff) begin
                           found = 1'b1;
                           fidx  = 3'(i);
                        end
                     end
                     if (hist_ff[0] == {1'b0, hall_ff} && hist_ff[1] == hist_ff[0]) begin
                        if (found) begin
                           mode_in     = MODE_RUN;
                           step_in     = fidx;
                           expected_in = step_next(fidx);
                           pending_in  = 1'b1;
                        end else begin
                           mode_in = MODE_ERROR;
                        end
                     end
                  end
                  default: begin
                     mode_in = (mode_ff == MODE_STOP) ? MODE_STOP : MODE_ERROR;
                     high_in = '{default: '0};
                     low_in  = '0;
                     if (prev_duty_ff == '0 && duty_ff != '0) mode_in = MODE_CHARGE;
                  end
               endcase
            end
            KIND_STALL: begin
               if (stall_ff != 8'hFF) stall_in = stall_ff + 8'd1;
            end
            KIND_RPM: begin
               if (timer_ff == '0) begin
                  phase_in = '0;
                  timer_in = 8'd1;
               end else if (timer_ff >= rpm_window_ff) begin
                  timer_in = '0;
                  upd_in   = 1'b1;
                  if (rpm_divisor_ff == '0) begin
                     speed_in = 8'hFF;
                  end else begin
                     // Dividend is phase_count * 10, built from two shifts.
                     sts.need_div = 1'b1;
                     rem_in = '0;
                     quo_in = {1'b0, phase_ff, 3'b000} + {3'b000, phase_ff, 1'b0};
                     cnt_in = DivCntWidth'(DivBits - 1);
                  end
               end else begin
                  timer_in = timer_ff + 8'd1;
               end
            end
            default: ;
         endcase
      end

      // One restoring division step per cycle, MSB first.
      if (cmd.div_step) begin
         rem_sh = {rem_ff[7:0], quo_ff[DivBits-1]};
         qn     = {quo_ff[DivBits-2:0], 1'b0};
         if (rem_sh >= {1'b0, rpm_divisor_ff}) begin
            rem_in = rem_sh - {1'b0, rpm_divisor_ff};
            qn[0]  = 1'b1;
         end else begin
            rem_in = rem_sh;
         end
         quo_in = qn;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) speed_in = (qn[DivBits-1:8] != '0) ? 8'hFF : qn[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOP;
         chg_phase_ff <= '0;
         chg_count_ff <= '0;
         stall_ff     <= '0;
         hist_ff      <= '{default: '0};
         step_ff      <= '0;
         expected_ff  <= '0;
         pending_ff   <= 1'b0;
         prev_duty_ff <= '0;
         phase_ff     <= '0;
         timer_ff     <= '0;
         high_ff      <= '{default: '0};
         low_ff       <= '0;
         speed_ff     <= '0;
         upd_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         chg_phase_ff <= chg_phase_in;
         chg_count_ff <= chg_count_in;
         stall_ff     <= stall_in;
         hist_ff      <= hist_in;
         step_ff      <= step_in;
         expected_ff  <= expected_in;
         pending_ff   <= pending_in;
         prev_duty_ff <= prev_duty_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         speed_ff     <= speed_in;
         upd_ff       <= upd_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_high_a_ff <= high_ff[0];
         out_high_b_ff <= high_ff[1];
         out_high_c_ff <= high_ff[2];
         out_low_ff    <= low_ff;
         out_mode_ff   <= mode_ff;
         out_speed_ff  <= speed_ff;
         out_upd_ff    <= upd_ff;
      end
   end

   assign rsp_tdata = {2'b00, out_speed_ff, out_mode_ff, out_low_ff,
                       out_high_c_ff, out_high_b_ff, out_high_a_ff};
   assign rsp_tuser = out_upd_ff;

endmodule

// ===== hdl/hall_bldc_commutation_controller.sv =====
// Hall sensor six-step commutation controller for a three-phase motor: top level.
//
// Input channel req_: one transaction per control step, stall tick or rpm tick;
// req_tuser carries the kind, req_tdata the duty and raw active-low Hall levels.
// Result channel rsp_: exactly one result per input transaction, in order,
// carrying the phase drive, mode, last speed and a speed-updated flag.
// Settings port csr_: always ready; write only while no transaction is in flight.
//
// One transaction is in work at a time: it is accepted in idle, applied in execute
// and loaded into the result register in done; the result is presented as the block
// returns to idle, and the next input can be accepted in that same cycle. An rpm
// tick that closes a measurement window runs the 20-step restoring divider for
// phases*10/divisor between execute and done.
// The result register holds one finished result; while the receiver stalls it
// keeps it, and the block accepts one more input and holds that result
// internally until the register frees, then stops accepting.
// Synchronous reset returns to the stop mode with all drives off and the
// settings at their defaults; no clearing pass is needed.
module hall_bldc_commutation_controller import hbcc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,  // duty[7:0], hall_levels[10:8], zero fill
   input  logic [1:0]              req_tuser,  // kind[1:0]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // high_a[7:0], high_b[15:8], high_c[23:16], low_a[24], low_b[25], low_c[26],
   // motor_mode[29:27], speed[37:30], zero fill
   output logic [39:0]             rsp_tdata,
   output logic [0:0]              rsp_tuser,  // speed_updated[0]
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CfgWidth-1:0]     csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   hbcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hbcc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== hdl/hbcc_checker.sv =====
// Port-level checker for the Hall commutation controller, with its bind statement.
module hbcc_checker import hbcc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only one transaction is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // At most one low-side switch is ever on, and no high side while charging or in position check.
   a_drive_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[26:24]) &&
                     (!(rsp_tdata[29:27] == MODE_CHARGE || rsp_tdata[29:27] == MODE_CHECK) ||
                      rsp_tdata[23:0] == 24'd0))
      else $error("unsafe phase drive");

endmodule

bind hall_bldc_commutation_controller hbcc_checker u_hbcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/commutation_checker.sv =====
// Checker for the Hall commutation controller: predicts each drive result and compares it.
module commutation_checker import hbcc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [15:0]             req_tdata,
   input  logic [1:0]              req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [39:0]             rsp_tdata,
   input  logic [0:0]              rsp_tuser,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CfgWidth-1:0]     csr_data,
   output int                      mismatch_count,
   output int                      outstanding
);

   typedef struct packed {
      logic [7:0] high_a;
      logic [7:0] high_b;
      logic [7:0] high_c;
      logic       low_a;
      logic       low_b;
      logic       low_c;
      mode_type   mode;
      logic [7:0] speed;
      logic       speed_updated;
   } drive_result;

   // Commutation tables, step 0 in the lowest bits.
   localparam logic [17:0] HALL_OF_STEP    = {3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd2};
   localparam logic [17:0] HALL_AFTER_STEP = {3'd2, 3'd6, 3'd4, 3'd5, 3'd1, 3'd3};
   localparam logic [11:0] HIGH_OF_STEP    = {2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
   localparam logic [11:0] LOW_OF_STEP     = {2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1};

   logic [7:0]  stall_window;
   logic [7:0]  charge_rounds;
   logic [7:0]  rpm_window;
   logic [7:0]  rpm_divisor;

   mode_type    motor_mode;
   logic [1:0]  charge_phase;
   logic [7:0]  rounds_done;
   logic [7:0]  stall_count;
   logic [3:0]  hall_hist [3];
   logic [2:0]  comm_step;
   logic [2:0]  next_hall;
   logic        write_pending;
   logic [7:0]  last_duty;
   logic [15:0] phase_count;
   logic [7:0]  window_timer;
   logic [7:0]  speed_value;
   logic [7:0]  drv_high [3];
   logic        drv_low [3];

   drive_result drive_expected [$];
   drive_result want;
   drive_result got;
   int          result_index;

   task automatic drive_all_off();
      for (int i = 0; i < 3; i++) begin
         drv_high[i] = 8'd0;
         drv_low[i]  = 1'b0;
      end
   endtask

   task automatic reset_model();
      stall_window  = 8'd50;
      charge_rounds = 8'd10;
      rpm_window    = 8'd100;
      rpm_divisor   = 8'd10;
      motor_mode    = MODE_STOP;
      charge_phase  = 2'd0;
      rounds_done   = 8'd0;
      stall_count   = 8'd0;
      for (int i = 0; i < 3; i++) hall_hist[i] = 4'd0;
      comm_step     = 3'd0;
      next_hall     = 3'd0;
      write_pending = 1'b0;
      last_duty     = 8'd0;
      phase_count   = 16'd0;
      window_timer  = 8'd0;
      speed_value   = 8'd0;
      result_index  = 0;
      drive_all_off();
   endtask

   task automatic apply_control(input logic [7:0] duty, input logic [2:0] code);
      case (motor_mode)
         MODE_RUN: begin
            if (duty == 8'd0) begin
               // The drive is kept until the next step after a stop request.
               motor_mode = MODE_STOP;
            end else begin
               if (code == next_hall) begin
                  comm_step     = (comm_step >= 3'd5) ? 3'd0 : comm_step + 3'd1;
                  write_pending = 1'b1;
                  next_hall     = HALL_AFTER_STEP[3*comm_step +: 3];
                  stall_count   = 8'd0;
                  if (phase_count != 16'hFFFF) phase_count = phase_count + 16'd1;
               end
               if (write_pending) begin
                  write_pending = 1'b0;
                  drive_all_off();
                  drv_high[HIGH_OF_STEP[2*comm_step +: 2]] = duty;
                  drv_low[LOW_OF_STEP[2*comm_step +: 2]]   = 1'b1;
               end
               if (stall_count >= stall_window) motor_mode = MODE_ERROR;
            end
         end
         MODE_CHARGE: begin
            drive_all_off();
            if (charge_phase < 2'd3) begin
               drv_low[charge_phase] = 1'b1;
               charge_phase = charge_phase + 2'd1;
            end else begin
               charge_phase = 2'd0;
               rounds_done  = rounds_done + 8'd1;
               if (rounds_done >= charge_rounds) begin
                  motor_mode  = MODE_CHECK;
                  rounds_done = 8'd0;
                  stall_count = 8'd0;
                  for (int i = 0; i < 3; i++) hall_hist[i] = HALL_EMPTY;
               end
            end
         end
         MODE_CHECK: begin
            hall_hist[2] = hall_hist[1];
            hall_hist[1] = hall_hist[0];
            hall_hist[0] = {1'b0, code};
            if (hall_hist[0] == hall_hist[1] && hall_hist[1] == hall_hist[2]) begin
               motor_mode = MODE_ERROR;
               for (int i = 0; i < 6; i++) begin
                  if (motor_mode == MODE_ERROR && HALL_OF_STEP[3*i +: 3] == code) begin
                     comm_step     = 3'(i);
                     next_hall     = HALL_AFTER_STEP[3*i +: 3];
                     write_pending = 1'b1;
                     motor_mode    = MODE_RUN;
                  end
               end
            end
         end
         default: begin
            motor_mode = (motor_mode == MODE_STOP) ? MODE_STOP : MODE_ERROR;
            drive_all_off();
            if (last_duty == 8'd0 && duty != 8'd0) motor_mode = MODE_CHARGE;
         end
      endcase
      last_duty = duty;
   endtask

   task automatic measure_speed(output logic updated);
      logic [31:0] scaled;
      updated = 1'b0;
      if (window_timer == 8'd0) begin
         phase_count  = 16'd0;
         window_timer = 8'd1;
      end else if (window_timer >= rpm_window) begin
         if (rpm_divisor == 8'd0) begin
            scaled = 32'd255;
         end else begin
            scaled = ({16'd0, phase_count} * 32'd10) / {24'd0, rpm_divisor};
            if (scaled > 32'd255) scaled = 32'd255;
         end
         speed_value  = scaled[7:0];
         window_timer = 8'd0;
         updated      = 1'b1;
      end else begin
         window_timer = window_timer + 8'd1;
      end
   endtask

   task automatic predict_item(input logic [1:0] kind, input logic [7:0] duty,
                               input logic [2:0] levels, output drive_result res);
      logic updated;
      updated = 1'b0;
      case (kind)
         KIND_CTRL:  apply_control(duty, ~levels);
         KIND_STALL: if (stall_count != 8'd255) stall_count = stall_count + 8'd1;
         KIND_RPM:   measure_speed(updated);
         default: ;
      endcase
      res.high_a        = drv_high[0];
      res.high_b        = drv_high[1];
      res.high_c        = drv_high[2];
      res.low_a         = drv_low[0];
      res.low_b         = drv_low[1];
      res.low_c         = drv_low[2];
      res.mode          = motor_mode;
      res.speed         = speed_value;
      res.speed_updated = updated;
   endtask

   function automatic string describe(drive_result r);
      return $sformatf("high %0d/%0d/%0d low %b%b%b mode %0d speed %0d new %b",
                       r.high_a, r.high_b, r.high_c, r.low_a, r.low_b, r.low_c,
                       r.mode, r.speed, r.speed_updated);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         drive_expected.delete();
         mismatch_count = 0;
         outstanding    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               REG_STALL_WINDOW:  stall_window  = csr_data;
               REG_CHARGE_ROUNDS: charge_rounds = csr_data;
               REG_RPM_WINDOW:    rpm_window    = csr_data;
               REG_RPM_DIVISOR:   rpm_divisor   = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.high_a        = rsp_tdata[7:0];
            got.high_b        = rsp_tdata[15:8];
            got.high_c        = rsp_tdata[23:16];
            got.low_a         = rsp_tdata[24];
            got.low_b         = rsp_tdata[25];
            got.low_c         = rsp_tdata[26];
            got.mode          = mode_type'(rsp_tdata[29:27]);
            got.speed         = rsp_tdata[37:30];
            got.speed_updated = rsp_tuser[0];
            if (drive_expected.size() == 0) begin
               if (mismatch_count < 10)
                  $display("result %0d arrived with nothing expected: %s",
                           result_index, describe(got));
               mismatch_count++;
            end else begin
               want = drive_expected.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10) begin
                     $display("result %0d mismatch", result_index);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(got));
                  end
                  mismatch_count++;
               end
            end
            result_index++;
         end
         if (req_tvalid && req_tready) begin
            predict_item(req_tuser, req_tdata[7:0], req_tdata[10:8], want);
            drive_expected.push_back(want);
         end
         outstanding = drive_expected.size();
      end
   end

endmodule

// ===== test/tb.sv =====
// Testbench top for the Hall commutation controller: clock, reset, stimulus and verdict.
module tb;
   import hbcc_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 500000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata = 16'd0;  // duty[7:0], hall_levels[10:8], zero fill
   logic [1:0]              req_tuser = 2'd0;   // kind[1:0]
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // high_a[7:0], high_b[15:8], high_c[23:16], low_a[24], low_b[25], low_c[26],
   // motor_mode[29:27], speed[37:30], zero fill
   logic [39:0]             rsp_tdata;
   logic [0:0]              rsp_tuser;          // speed_updated[0]
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrAddrWidth-1:0] csr_addr = '0;
   logic [CfgWidth-1:0]     csr_data = '0;

   int mismatch_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent = 0;
   int cycle_count = 0;

   hall_bldc_commutation_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   commutation_checker drive_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_addr       (csr_addr),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] duty,
                            input logic [2:0] levels);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, levels, duty};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // Control steps take the Hall code; the pins carry it inverted.
   task automatic send_ctrl(input logic [7:0] duty, input logic [2:0] code);
      send_item(KIND_CTRL, duty, ~code);
   endtask

   task automatic side_traffic(input int rpm_pct);
      while ($urandom_range(99) < rpm_pct)
         send_item(KIND_RPM, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      if ($urandom_range(99) < 6)
         send_item(KIND_STALL, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      if ($urandom_range(99) < 2)
         send_item(KIND_SPARE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] stall_win, input logic [7:0] rounds,
                             input logic [7:0] rpm_win, input logic [7:0] divisor);
      logic [CsrAddrWidth-1:0] regs [4];
      logic [CfgWidth-1:0]     vals [4];
      regs = '{REG_STALL_WINDOW, REG_CHARGE_ROUNDS, REG_RPM_WINDOW, REG_RPM_DIVISOR};
      vals = '{stall_win, rounds, rpm_win, divisor};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_addr  <= regs[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // One pass stop -> charging -> position check -> running -> stop, with ticks
   // mixed in. About one pass in eight locks onto an invalid Hall code instead.
   task automatic motor_sequence(input int rounds, input int rpm_pct);
      int         charge_steps;
      int         run_len;
      logic [2:0] step;
      logic [2:0] code;
      logic [2:0] target;
      charge_steps = 4 * ((rounds == 0) ? 1 : rounds);
      if (charge_steps > 40) charge_steps = 40;
      send_ctrl(8'd0, 3'($urandom_range(0, 7)));
      send_ctrl(8'($urandom_range(1, 255)), 3'($urandom_range(0, 7)));
      repeat (charge_steps) begin
         side_traffic(rpm_pct);
         send_ctrl(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end
      repeat ($urandom_range(0, 2)) begin
         side_traffic(rpm_pct);
         send_ctrl(8'($urandom_range(1, 255)), 3'($urandom_range(0, 7)));
      end
      step = 3'($urandom_range(0, 5));
      if ($urandom_range(0, 7) == 0)
         target = ($urandom_range(0, 1) == 1) ? 3'd7 : 3'd0;
      else
         target = step_hall(step);
      repeat (3) begin
         side_traffic(rpm_pct);
         send_ctrl(8'($urandom_range(1, 255)), target);
      end
      run_len = $urandom_range(4, 40);
      repeat (run_len) begin
         side_traffic(rpm_pct);
         if ($urandom_range(99) < 75) code = step_next(step);
         else code = 3'($urandom_range(0, 7));
         if (code == step_next(step)) step = (step == 3'd5) ? 3'd0 : step + 3'd1;
         send_ctrl(8'($urandom_range(1, 255)), code);
      end
      side_traffic(rpm_pct);
      send_ctrl(8'd0, 3'($urandom_range(0, 7)));
   endtask

   task automatic run_phase(input logic [7:0] stall_win, input logic [7:0] rounds,
                            input logic [7:0] rpm_win, input logic [7:0] divisor,
                            input int snd_pct, input int rcv_pct, input int items,
                            input int rpm_pct);
      int target;
      wait_quiet();
      set_config(stall_win, rounds, rpm_win, divisor);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      target = sent + items;
      while (sent < target) motor_sequence(rounds, rpm_pct);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 33;
      recv_idle_pct = 54;

      // Directed: zero charge rounds, zero stall window, zero divisor, unused kind,
      // invalid Hall code at position check.
      set_config(8'd0, 8'd0, 8'd1, 8'd0);
      send_item(KIND_SPARE, 8'd255, 3'd7);
      send_ctrl(8'd0, 3'd0);
      send_ctrl(8'd255, 3'd7);
      repeat (4) send_ctrl(8'd255, 3'd0);
      repeat (3) send_ctrl(8'd255, 3'd2);
      send_ctrl(8'd128, 3'd3);
      send_item(KIND_RPM, 8'd0, 3'd0);
      send_item(KIND_RPM, 8'd255, 3'd7);
      send_item(KIND_STALL, 8'd85, 3'd5);
      send_ctrl(8'd0, 3'd1);
      send_ctrl(8'd1, 3'd6);
      repeat (4) send_ctrl(8'd170, 3'd4);
      repeat (3) send_ctrl(8'd255, 3'd7);
      send_item(KIND_STALL, 8'd0, 3'd7);

      // A pass with heavy rpm traffic alone runs past 300 items.
      run_phase(8'd255, 8'd1,   8'd2,   8'd1,   33, 54, 170, 15);
      run_phase(8'd3,   8'd2,   8'd5,   8'd255, 33, 54, 170, 10);
      run_phase(8'd40,  8'd1,   8'd255, 8'd7,   54, 33, 250, 90);
      run_phase(8'd50,  8'd1,   8'd20,  8'd1,   54, 33, 170, 8);
      run_phase(8'd10,  8'd3,   8'd0,   8'd3,   0,  0,  150, 20);
      run_phase(8'd0,   8'd1,   8'd3,   8'd2,   0,  0,  100, 10);
      run_phase(8'd255, 8'd255, 8'd255, 8'd255, 0,  0,  60,  10);

      wait_quiet();
      repeat (30) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
